### rtl/tkrt_pkg.sv
`timescale 1ns / 1ps

package tkrt_pkg;

   localparam int KIND_W   = 3;
   localparam int NOW_W    = 32;
   localparam int KEY_W    = 64;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 2;
   localparam int COUNT_W  = 3;
   localparam int ROT_W    = 32;

   localparam logic [KIND_W-1:0] KIND_CHECK  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FORCE  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FIND   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_PURGE  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ACTIVE = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_ACTIVE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_MATCH  = 2'd2;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROT_INTERVAL = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRACE        = 1'd1;
   localparam logic [CSR_DATA_W-1:0]  ROT_INTERVAL_RESET = 32'd3600;
   localparam logic [CSR_DATA_W-1:0]  GRACE_RESET        = 32'd1800;

   // decoded request
   typedef struct packed {
      logic rotate;
      logic forced;
      logic find;
      logic purge;
      logic active;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic valid;
   } fifo_stat_type;

endpackage

### rtl/tkrt_front.sv
`timescale 1ns / 1ps

module tkrt_front #(
   parameter int TIME_BITS = 32,
   parameter int NAME_BITS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tkrt_pkg::KIND_W-1:0]   req_kind,
   input  logic [tkrt_pkg::NOW_W-1:0]    req_now_time,
   input  logic [tkrt_pkg::KEY_W-1:0]    req_key_name,
   input  logic                          q_pop,
   output tkrt_pkg::cmd_type             q_cmd,
   output logic [TIME_BITS-1:0]          q_now,
   output logic [NAME_BITS-1:0]          q_name,
   output tkrt_pkg::fifo_stat_type       q_stat
);

   tkrt_pkg::cmd_type           cmd_ff [2];
   logic [TIME_BITS-1:0]        now_ff [2];
   logic [NAME_BITS-1:0]        name_ff [2];
   logic                        wr_ptr_ff, wr_ptr_in;
   logic                        rd_ptr_ff, rd_ptr_in;
   logic [1:0]                  cnt_ff, cnt_in;

   tkrt_pkg::cmd_type           cmd_dec;
   logic [TIME_BITS+tkrt_pkg::NOW_W-1:0] now_ext;
   logic                        push;
   logic                        pop;

   always_comb begin
      cmd_dec = '0;
      unique case (req_kind)
         tkrt_pkg::KIND_CHECK: cmd_dec.rotate = 1'b1;
         tkrt_pkg::KIND_FORCE: begin
            cmd_dec.rotate = 1'b1;
            cmd_dec.forced = 1'b1;
         end
         tkrt_pkg::KIND_FIND:   cmd_dec.find   = 1'b1;
         tkrt_pkg::KIND_PURGE:  cmd_dec.purge  = 1'b1;
         tkrt_pkg::KIND_ACTIVE: cmd_dec.active = 1'b1;
         default:               cmd_dec = '0;
      endcase
   end

   assign now_ext = {{TIME_BITS{1'b0}}, req_now_time};

   assign q_stat.full  = (cnt_ff == 2'd2);
   assign q_stat.valid = (cnt_ff != 2'd0);
   assign req_stall    = q_stat.full;
   assign push         = req_valid && !q_stat.full;
   assign pop          = q_pop && q_stat.valid;

   assign q_cmd  = cmd_ff[rd_ptr_ff];
   assign q_now  = now_ff[rd_ptr_ff];
   assign q_name = name_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cmd_ff[wr_ptr_ff]  <= cmd_dec;
         now_ff[wr_ptr_ff]  <= now_ext[TIME_BITS-1:0];
         name_ff[wr_ptr_ff] <= req_key_name[NAME_BITS-1:0];
      end
   end

endmodule

### rtl/tkrt_back.sv
`timescale 1ns / 1ps

module tkrt_back #(
   parameter int TABLE_SLOTS = 4,
   parameter int NAME_BITS   = 64,
   parameter int TIME_BITS   = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   output logic                            q_pop,
   input  tkrt_pkg::cmd_type               q_cmd,
   input  logic [TIME_BITS-1:0]            q_now,
   input  logic [NAME_BITS-1:0]            q_name,
   input  logic [tkrt_pkg::CSR_DATA_W-1:0] rotation_interval,
   input  logic [tkrt_pkg::CSR_DATA_W-1:0] grace_period,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [tkrt_pkg::STATUS_W-1:0]   rsp_status,
   output logic                            rsp_rotated,
   output logic [tkrt_pkg::SLOT_W-1:0]     rsp_slot,
   output logic [tkrt_pkg::COUNT_W-1:0]    rsp_purged,
   output logic [tkrt_pkg::COUNT_W-1:0]    rsp_occupied,
   output logic [tkrt_pkg::ROT_W-1:0]      rsp_rotation_count
);

   localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
   localparam int EXP_W = TIME_BITS + 2;
   localparam int SUM_W = ((TIME_BITS > 32) ? TIME_BITS : 32) + 2;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_WRITE  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   // slot table
   logic [TIME_BITS-1:0] created_ff [TABLE_SLOTS];
   logic [TIME_BITS-1:0] created_in [TABLE_SLOTS];
   logic [EXP_W-1:0]     expires_ff [TABLE_SLOTS];
   logic [EXP_W-1:0]     expires_in [TABLE_SLOTS];
   logic [NAME_BITS-1:0] name_ff [TABLE_SLOTS];
   logic [NAME_BITS-1:0] name_in [TABLE_SLOTS];
   logic [TABLE_SLOTS-1:0] live_ff, live_in;
   logic                 cur_valid_ff, cur_valid_in;
   logic [IDX_W-1:0]     cur_slot_ff, cur_slot_in;
   logic [tkrt_pkg::ROT_W-1:0] counter_ff, counter_in;
   logic [CNT_W-1:0]     occ_ff, occ_in;

   // per-request working state
   logic [2:0]           state_ff, state_in;
   tkrt_pkg::cmd_type    cmd_ff, cmd_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [NAME_BITS-1:0] key_ff, key_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 free_found_ff, free_found_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;
   logic                 old_found_ff, old_found_in;
   logic [IDX_W-1:0]     old_idx_ff, old_idx_in;
   logic [TIME_BITS-1:0] oldest_ff, oldest_in;
   logic [TIME_BITS-1:0] cur_created_ff, cur_created_in;
   logic [SUM_W-1:0]     part_ff, part_in;
   logic                 match_ff, match_in;
   logic [CNT_W-1:0]     purged_ff, purged_in;
   logic                 rotated_ff, rotated_in;
   logic [IDX_W-1:0]     res_slot_ff, res_slot_in;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [tkrt_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                         rsp_rotated_ff, rsp_rotated_in;
   logic [tkrt_pkg::SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [tkrt_pkg::COUNT_W-1:0] rsp_purged_ff, rsp_purged_in;
   logic [tkrt_pkg::COUNT_W-1:0] rsp_occ_ff, rsp_occ_in;
   logic [tkrt_pkg::ROT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic [TIME_BITS-1:0] scan_created;
   logic                 scan_used;
   logic                 scan_expired;
   logic                 scan_protected;
   logic                 due;
   logic [IDX_W-1:0]     pick;
   logic                 active_ok;
   logic [IDX_W-1:0]     slot_sel;
   logic [IDX_W+1:0]     slot_ext;
   logic [CNT_W+2:0]     purged_ext;
   logic [CNT_W+2:0]     occ_ext;

   assign scan_created   = created_ff[idx_ff];
   assign scan_used      = (scan_created != '0);
   assign scan_expired   = (EXP_W'(now_ff) > expires_ff[idx_ff]);
   assign scan_protected = cur_valid_ff && (idx_ff == cur_slot_ff) && live_ff[idx_ff];
   assign due = (SUM_W'(now_ff) >= (SUM_W'(cur_created_ff) + SUM_W'(rotation_interval)));
   assign pick = free_found_ff ? free_idx_ff : (old_found_ff ? old_idx_ff : '0);
   assign active_ok = cur_valid_ff && live_ff[cur_slot_ff];
   assign slot_sel = (cmd_ff.active && active_ok) ? cur_slot_ff : res_slot_ff;
   assign slot_ext   = {2'b00, slot_sel};
   assign purged_ext = {3'b000, purged_ff};
   assign occ_ext    = {3'b000, occ_ff};

   always_comb begin
      created_in     = created_ff;
      expires_in     = expires_ff;
      name_in        = name_ff;
      live_in        = live_ff;
      cur_valid_in   = cur_valid_ff;
      cur_slot_in    = cur_slot_ff;
      counter_in     = counter_ff;
      occ_in         = occ_ff;
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      now_in         = now_ff;
      key_in         = key_ff;
      idx_in         = idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      old_found_in   = old_found_ff;
      old_idx_in     = old_idx_ff;
      oldest_in      = oldest_ff;
      cur_created_in = cur_created_ff;
      part_in        = part_ff;
      match_in       = match_ff;
      purged_in      = purged_ff;
      rotated_in     = rotated_ff;
      res_slot_in    = res_slot_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_rotated_in = rsp_rotated_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_purged_in  = rsp_purged_ff;
      rsp_occ_in     = rsp_occ_ff;
      rsp_count_in   = rsp_count_ff;
      q_pop          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop         = 1'b1;
               cmd_in        = q_cmd;
               now_in        = q_now;
               key_in        = q_name;
               idx_in        = '0;
               free_found_in = 1'b0;
               old_found_in  = 1'b0;
               oldest_in     = q_now;
               match_in      = 1'b0;
               purged_in     = '0;
               rotated_in    = 1'b0;
               res_slot_in   = '0;
               part_in       = SUM_W'(q_now) + SUM_W'(rotation_interval);
               state_in      = (q_cmd.rotate || q_cmd.find || q_cmd.purge) ?
                               ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            if (cmd_ff.rotate) begin
               if (idx_ff == cur_slot_ff) begin
                  cur_created_in = scan_created;
               end
               if (!scan_used && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = idx_ff;
               end
               if (scan_created < oldest_ff) begin
                  oldest_in    = scan_created;
                  old_idx_in   = idx_ff;
                  old_found_in = 1'b1;
               end
            end
            if (cmd_ff.find && !match_ff && scan_used && !scan_expired &&
                (name_ff[idx_ff] == key_ff)) begin
               match_in    = 1'b1;
               res_slot_in = idx_ff;
            end
            if (cmd_ff.purge && scan_used && !scan_protected && scan_expired) begin
               created_in[idx_ff] = '0;
               live_in[idx_ff]    = 1'b0;
               purged_in          = purged_ff + CNT_W'(1);
               occ_in             = occ_ff - CNT_W'(1);
            end
            if (idx_ff == LAST_IDX) begin
               state_in = cmd_ff.rotate ? ST_DECIDE : ST_FINISH;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_DECIDE: begin
            if (cmd_ff.forced || !cur_valid_ff || due) begin
               state_in = ST_WRITE;
            end else begin
               res_slot_in = cur_slot_ff;
               state_in    = ST_FINISH;
            end
         end
         ST_WRITE: begin
            if (cur_valid_ff) begin
               live_in[cur_slot_ff] = 1'b0;
            end
            live_in[pick]    = 1'b1;
            created_in[pick] = now_ff;
            expires_in[pick] = EXP_W'(part_ff + SUM_W'(grace_period));
            name_in[pick]    = key_ff;
            counter_in       = counter_ff + tkrt_pkg::ROT_W'(1);
            occ_in           = occ_ff + CNT_W'(now_ff != '0) - CNT_W'(!free_found_ff);
            cur_slot_in      = pick;
            cur_valid_in     = 1'b1;
            rotated_in       = 1'b1;
            res_slot_in      = pick;
            state_in         = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (cmd_ff.find && !match_ff) begin
                  rsp_status_in = tkrt_pkg::STATUS_NO_MATCH;
               end else if (cmd_ff.active && !active_ok) begin
                  rsp_status_in = tkrt_pkg::STATUS_NO_ACTIVE;
               end else begin
                  rsp_status_in = tkrt_pkg::STATUS_OK;
               end
               rsp_rotated_in = rotated_ff;
               rsp_slot_in    = slot_ext[tkrt_pkg::SLOT_W-1:0];
               rsp_purged_in  = purged_ext[tkrt_pkg::COUNT_W-1:0];
               rsp_occ_in     = occ_ext[tkrt_pkg::COUNT_W-1:0];
               rsp_count_in   = counter_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cur_valid_ff <= 1'b0;
         cur_slot_ff  <= '0;
         counter_ff   <= '0;
         occ_ff       <= '0;
         live_ff      <= '0;
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            created_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_valid_ff <= cur_valid_in;
         cur_slot_ff  <= cur_slot_in;
         counter_ff   <= counter_in;
         occ_ff       <= occ_in;
         live_ff      <= live_in;
         created_ff   <= created_in;
      end
   end

   always_ff @(posedge clock) begin
      expires_ff     <= expires_in;
      name_ff        <= name_in;
      cmd_ff         <= cmd_in;
      now_ff         <= now_in;
      key_ff         <= key_in;
      idx_ff         <= idx_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      old_found_ff   <= old_found_in;
      old_idx_ff     <= old_idx_in;
      oldest_ff      <= oldest_in;
      cur_created_ff <= cur_created_in;
      part_ff        <= part_in;
      match_ff       <= match_in;
      purged_ff      <= purged_in;
      rotated_ff     <= rotated_in;
      res_slot_ff    <= res_slot_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_rotated_ff <= rsp_rotated_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_purged_ff  <= rsp_purged_in;
      rsp_occ_ff     <= rsp_occ_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_rotated        = rsp_rotated_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_purged         = rsp_purged_ff;
   assign rsp_occupied       = rsp_occ_ff;
   assign rsp_rotation_count = rsp_count_ff;

endmodule

### rtl/ticket_key_rotation_table.sv
`timescale 1ns / 1ps

// channel   ports                                            direction
// request   req_valid req_stall req_kind req_now_time         in
//           req_key_name
// response  rsp_valid rsp_stall rsp_status rsp_rotated        out
//           rsp_slot rsp_purged rsp_occupied rsp_rotation_count
// csr       csr_write_enable csr_index csr_write_data         in
//
// The back end scans the table one slot per cycle for lookup, purge and rotation
// requests; a rotation then decides and writes the new key, a check that keeps the
// current key only decides, and get_active and unused kinds skip the scan.
// A two-entry queue takes requests while the back end works or a response waits.
// Synchronous reset empties the table and the queue; no clearing pass.

module ticket_key_rotation_table #(
   parameter int TABLE_SLOTS = 4,
   parameter int NAME_BITS   = 64,
   parameter int TIME_BITS   = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [tkrt_pkg::KIND_W-1:0]       req_kind,
   input  logic [tkrt_pkg::NOW_W-1:0]        req_now_time,
   input  logic [tkrt_pkg::KEY_W-1:0]        req_key_name,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tkrt_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_rotated,
   output logic [tkrt_pkg::SLOT_W-1:0]       rsp_slot,
   output logic [tkrt_pkg::COUNT_W-1:0]      rsp_purged,
   output logic [tkrt_pkg::COUNT_W-1:0]      rsp_occupied,
   output logic [tkrt_pkg::ROT_W-1:0]        rsp_rotation_count,
   input  logic                              csr_write_enable,
   input  logic [tkrt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tkrt_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   logic [tkrt_pkg::CSR_DATA_W-1:0] interval_ff, interval_in;
   logic [tkrt_pkg::CSR_DATA_W-1:0] grace_ff, grace_in;

   tkrt_pkg::cmd_type       q_cmd;
   tkrt_pkg::fifo_stat_type q_stat;
   logic [TIME_BITS-1:0]    q_now;
   logic [NAME_BITS-1:0]    q_name;
   logic                    q_pop;

   always_comb begin
      interval_in = interval_ff;
      grace_in    = grace_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            tkrt_pkg::CSR_ROT_INTERVAL: interval_in = csr_write_data;
            tkrt_pkg::CSR_GRACE:        grace_in    = csr_write_data;
            default:                    interval_in = interval_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= tkrt_pkg::ROT_INTERVAL_RESET;
         grace_ff    <= tkrt_pkg::GRACE_RESET;
      end else begin
         interval_ff <= interval_in;
         grace_ff    <= grace_in;
      end
   end

   tkrt_front #(
      .TIME_BITS (TIME_BITS),
      .NAME_BITS (NAME_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_kind     (req_kind),
      .req_now_time (req_now_time),
      .req_key_name (req_key_name),
      .q_pop        (q_pop),
      .q_cmd        (q_cmd),
      .q_now        (q_now),
      .q_name       (q_name),
      .q_stat       (q_stat)
   );

   tkrt_back #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .NAME_BITS   (NAME_BITS),
      .TIME_BITS   (TIME_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_stat.valid),
      .q_pop              (q_pop),
      .q_cmd              (q_cmd),
      .q_now              (q_now),
      .q_name             (q_name),
      .rotation_interval  (interval_ff),
      .grace_period       (grace_ff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_rotated        (rsp_rotated),
      .rsp_slot           (rsp_slot),
      .rsp_purged         (rsp_purged),
      .rsp_occupied       (rsp_occupied),
      .rsp_rotation_count (rsp_rotation_count)
   );

`ifndef SYNTHESIS
   a_rotated_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rotated) |-> (rsp_status == tkrt_pkg::STATUS_OK))
      else $error("rotated response with failing status");

   a_no_match_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == tkrt_pkg::STATUS_NO_MATCH) |->
      (rsp_slot == '0 && !rsp_rotated && rsp_purged == '0))
      else $error("failed lookup reports a slot or side effect");

   a_purge_exclusive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_purged != '0) |->
      (!rsp_rotated && rsp_status == tkrt_pkg::STATUS_OK && rsp_slot == '0))
      else $error("purge response mixed with other results");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_stat.valid)
      else $error("back end popped an empty queue");
`endif

endmodule
